// ===== hw/rtl/hfc_pkg.sv =====
`default_nettype none
package hfc_pkg;

    localparam int MAX_FRAME_LEN = 1024;
    localparam int MIN_FRAME_LEN = 9;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [10:0] COUNT_MAX = 11'h7FF;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_FRAME    = 3'd2,
        ST_BAD_NODE     = 3'd3,
        ST_FCS_NOT_HEX  = 3'd4,
        ST_FCS_MISMATCH = 3'd5,
        ST_TOO_LONG     = 3'd6
    } status_t;

    // one queue entry per request that yields results
    typedef struct packed {
        logic        text_valid;
        logic [7:0]  text;
        logic        fin;
        logic [6:0]  node;
        logic [7:0]  hdr_first;
        logic [7:0]  hdr_second;
        logic [9:0]  text_count;
        status_t     status;
    } hfc_entry_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE]});
    endfunction

    // bit 4 set: not a hex character
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            r = {1'b0, c[3:0]};
        end else if ((c inside {[CH_UA:CH_UF]}) || (c inside {[CH_LA:CH_LF]})) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hostlink_frame_checker.sv =====
// Host link frame checker.
// Input channel s_*: one frame byte per request, s_final_byte on the last byte
// of the frame. Result channel m_*: text bytes (m_kind 0) are passed on four
// bytes late and unconfirmed; on the final byte a status request (m_kind 1)
// carries node, header, text length and error code. m_run_end marks the last
// result caused by one input byte.
// Throughput: one input byte per cycle while s_ready is high. The final byte of a
// frame with text gives two results from one queue entry, each its own output
// transfer; a four-entry queue between the parser and the output stage absorbs that.
// A result passes through the queue and then the output register before it is
// presented on m_valid, and waits in the queue while the output stage is busy.
// A stalled m_ready holds the output register; the queue keeps taking bytes
// until it fills, then s_ready drops.
// Reset (aresetn low, synchronous) clears the frame state, the queue and the
// output stage; no clearing pass, input is taken in the first cycle after.
`default_nettype none
module hostlink_frame_checker import hfc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_final_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_kind,
    output logic [7:0]      m_text_byte,
    output logic [6:0]      m_node_number,
    output logic [7:0]      m_header_first,
    output logic [7:0]      m_header_second,
    output logic [9:0]      m_text_length,
    output logic [2:0]      m_status,
    output logic            m_run_end
);

    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    hfc_entry_t push_entry;
    hfc_entry_t head_entry;

    hfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_data    (s_data_byte),
        .in_final   (s_final_byte),
        .q_full     (q_full),
        .in_ready   (s_ready),
        .push       (push),
        .push_entry (push_entry)
    );

    hfc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_entry),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (head_entry),
        .empty   (q_empty)
    );

    hfc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .entry          (head_entry),
        .q_empty        (q_empty),
        .pop            (pop),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_kind       (m_kind),
        .out_text       (m_text_byte),
        .out_node       (m_node_number),
        .out_hdr_first  (m_header_first),
        .out_hdr_second (m_header_second),
        .out_text_len   (m_text_length),
        .out_status     (m_status),
        .out_run_end    (m_run_end)
    );

    a_status_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_run_end)
        else $error("status request without run end");

    a_text_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_status == 3'(ST_OK) && m_node_number == 7'd0
                               && m_text_length == 10'd0)
        else $error("text request carries status fields");

    a_error_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind && m_status != 3'(ST_OK) |->
            m_node_number == 7'd0 && m_text_length == 10'd0 && m_header_first == 8'd0)
        else $error("failed frame reports payload");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

// ===== hw/rtl/hfc_front.sv =====
`default_nettype none
module hfc_front import hfc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_data,
    input  wire logic       in_final,
    input  wire logic       q_full,
    output logic            in_ready,
    output logic            push,
    output hfc_entry_t      push_entry
);

    logic [10:0] count_reg,   count_next;
    logic [7:0]  tail_reg [4];
    logic [7:0]  tail_next [4];
    logic [7:0]  xor_reg,     xor_next;
    logic        start_reg,   start_next;
    logic        node_ok_reg, node_ok_next;
    logic [6:0]  node_reg,    node_next;
    logic [7:0]  hdr0_reg,    hdr0_next;
    logic [7:0]  hdr1_reg,    hdr1_next;

    logic        accept;
    logic        text_v;
    logic        ok2;
    logic [4:0]  hi_n;
    logic [4:0]  lo_n;
    logic [10:0] tl_full;
    status_t     st;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        count_next   = count_reg;
        tail_next    = tail_reg;
        xor_next     = xor_reg;
        start_next   = start_reg;
        node_ok_next = node_ok_reg;
        node_next    = node_reg;
        hdr0_next    = hdr0_reg;
        hdr1_next    = hdr1_reg;
        ok2          = node_ok_reg && is_digit(in_data);

        if (count_reg == 11'd0) begin
            start_next = (in_data == CH_AT);
        end
        if (count_reg == 11'd1) begin
            node_ok_next = is_digit(in_data);
            node_next    = is_digit(in_data) ? 7'(in_data[3:0]) * 7'd10 : 7'd0;
        end
        if (count_reg == 11'd2) begin
            node_ok_next = ok2;
            if (ok2) begin
                node_next = node_reg + 7'(in_data[3:0]);
            end
        end
        if (count_reg == 11'd3) begin
            hdr0_next = in_data;
        end
        if (count_reg == 11'd4) begin
            hdr1_next = in_data;
        end
        if (count_reg >= 11'd4) begin
            xor_next = xor_reg ^ tail_reg[3];
        end

        text_v = (count_reg >= 11'(MIN_FRAME_LEN));

        // status, valid only on the final byte
        hi_n    = hex_nibble(tail_reg[2]);
        lo_n    = hex_nibble(tail_reg[1]);
        tl_full = count_reg - 11'(MIN_FRAME_LEN - 1);
        if (count_reg < 11'(MIN_FRAME_LEN - 1)) begin
            st = ST_SHORT;
        end else if (count_reg == COUNT_MAX
                     || {21'd0, count_reg} >= 32'(MAX_FRAME_LEN)) begin
            st = ST_TOO_LONG;
        end else if (!start_reg || tail_reg[0] != CH_STAR || in_data != CH_CR) begin
            st = ST_BAD_FRAME;
        end else if (!node_ok_reg) begin
            st = ST_BAD_NODE;
        end else if (hi_n[4] || lo_n[4]) begin
            st = ST_FCS_NOT_HEX;
        end else if ({hi_n[3:0], lo_n[3:0]} != xor_next) begin
            st = ST_FCS_MISMATCH;
        end else begin
            st = ST_OK;
        end

        push_entry.text_valid = text_v;
        push_entry.text       = tail_reg[3];
        push_entry.fin        = in_final;
        push_entry.status     = st;
        if (st == ST_OK) begin
            push_entry.node       = node_reg;
            push_entry.hdr_first  = hdr0_reg;
            push_entry.hdr_second = hdr1_reg;
            push_entry.text_count = (tl_full > 11'd1023) ? 10'd1023 : tl_full[9:0];
        end else begin
            push_entry.node       = 7'd0;
            push_entry.hdr_first  = 8'd0;
            push_entry.hdr_second = 8'd0;
            push_entry.text_count = 10'd0;
        end

        if (!in_final) begin
            tail_next[3] = tail_reg[2];
            tail_next[2] = tail_reg[1];
            tail_next[1] = tail_reg[0];
            tail_next[0] = in_data;
            if (count_reg < COUNT_MAX) begin
                count_next = count_reg + 11'd1;
            end
        end else begin
            count_next   = 11'd0;
            tail_next    = '{default: 8'd0};
            xor_next     = 8'd0;
            start_next   = 1'b0;
            node_ok_next = 1'b0;
            node_next    = 7'd0;
            hdr0_next    = 8'd0;
            hdr1_next    = 8'd0;
        end
    end

    assign push = accept && (text_v || in_final);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= 11'd0;
            tail_reg    <= '{default: 8'd0};
            xor_reg     <= 8'd0;
            start_reg   <= 1'b0;
            node_ok_reg <= 1'b0;
            node_reg    <= 7'd0;
            hdr0_reg    <= 8'd0;
            hdr1_reg    <= 8'd0;
        end else if (accept) begin
            count_reg   <= count_next;
            tail_reg    <= tail_next;
            xor_reg     <= xor_next;
            start_reg   <= start_next;
            node_ok_reg <= node_ok_next;
            node_reg    <= node_next;
            hdr0_reg    <= hdr0_next;
            hdr1_reg    <= hdr1_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hfc_queue.sv =====
`default_nettype none
module hfc_queue import hfc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       wr_en,
    input  wire hfc_entry_t wr_data,
    output logic            full,
    input  wire logic       rd_en,
    output hfc_entry_t      rd_data,
    output logic            empty
);

    hfc_entry_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]      cnt_reg,    cnt_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hfc_back.sv =====
`default_nettype none
module hfc_back import hfc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire hfc_entry_t entry,
    input  wire logic       q_empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            out_kind,
    output logic [7:0]      out_text,
    output logic [6:0]      out_node,
    output logic [7:0]      out_hdr_first,
    output logic [7:0]      out_hdr_second,
    output logic [9:0]      out_text_len,
    output logic [2:0]      out_status,
    output logic            out_run_end
);

    logic        valid_reg,  valid_next;
    logic        phase_reg,  phase_next;
    logic        kind_reg,   kind_next;
    logic [7:0]  text_reg,   text_next;
    logic [6:0]  node_reg,   node_next;
    logic [7:0]  hdr0_reg,   hdr0_next;
    logic [7:0]  hdr1_reg,   hdr1_next;
    logic [9:0]  tlen_reg,   tlen_next;
    status_t     st_reg,     st_next;
    logic        end_reg,    end_next;
    logic        load;

    assign load = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        text_next  = text_reg;
        node_next  = node_reg;
        hdr0_next  = hdr0_reg;
        hdr1_next  = hdr1_reg;
        tlen_next  = tlen_reg;
        st_next    = st_reg;
        end_next   = end_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                if (entry.text_valid && !phase_reg) begin
                    kind_next  = 1'b0;
                    text_next  = entry.text;
                    node_next  = 7'd0;
                    hdr0_next  = 8'd0;
                    hdr1_next  = 8'd0;
                    tlen_next  = 10'd0;
                    st_next    = ST_OK;
                    end_next   = !entry.fin;
                    phase_next = entry.fin;
                    pop        = !entry.fin;
                end else begin
                    kind_next  = 1'b1;
                    text_next  = 8'd0;
                    node_next  = entry.node;
                    hdr0_next  = entry.hdr_first;
                    hdr1_next  = entry.hdr_second;
                    tlen_next  = entry.text_count;
                    st_next    = entry.status;
                    end_next   = 1'b1;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        text_reg <= text_next;
        node_reg <= node_next;
        hdr0_reg <= hdr0_next;
        hdr1_reg <= hdr1_next;
        tlen_reg <= tlen_next;
        st_reg   <= st_next;
        end_reg  <= end_next;
    end

    assign out_valid      = valid_reg;
    assign out_kind       = kind_reg;
    assign out_text       = text_reg;
    assign out_node       = node_reg;
    assign out_hdr_first  = hdr0_reg;
    assign out_hdr_second = hdr1_reg;
    assign out_text_len   = tlen_reg;
    assign out_status     = st_reg;
    assign out_run_end    = end_reg;

endmodule
`default_nettype wire

// ===== bench/tb_hostlink_frame_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_hostlink_frame_checker;
    import hfc_pkg::*;

    localparam logic KIND_TEXT   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam int   TAIL_DEPTH  = 4;
    localparam int   TAIL_FIRST  = 9;
    localparam int   TLEN_CAP    = 1023;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text;
        logic [6:0]  node;
        logic [7:0]  hdr_first;
        logic [7:0]  hdr_second;
        logic [9:0]  text_count;
        status_t     status;
        logic        run_end;
    } link_result_t;

    typedef struct {
        logic [7:0]   data;
        logic         last;
        logic         typed;
        link_result_t res;
    } probe_row_t;

    typedef enum int {
        FT_NONE,
        FT_NOISE,
        FT_BAD_START,
        FT_BAD_STAR,
        FT_BAD_CR,
        FT_BAD_NODE,
        FT_FCS_NOT_HEX,
        FT_FCS_WRONG
    } frame_fault_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_final_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_kind;
    logic [7:0] m_text_byte;
    logic [6:0] m_node_number;
    logic [7:0] m_header_first;
    logic [7:0] m_header_second;
    logic [9:0] m_text_length;
    logic [2:0] m_status;
    logic       m_run_end;

    hostlink_frame_checker DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_final_byte    (s_final_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_text_byte     (m_text_byte),
        .m_node_number   (m_node_number),
        .m_header_first  (m_header_first),
        .m_header_second (m_header_second),
        .m_text_length   (m_text_length),
        .m_status        (m_status),
        .m_run_end       (m_run_end)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic [10:0] seen_count = '0;
    logic [7:0]  tail [TAIL_DEPTH];
    logic [7:0]  fcs_acc = '0;
    logic        start_good = 1'b0;
    logic        node_good = 1'b0;
    logic [6:0]  node_val = '0;
    logic [7:0]  hdr [2];

    link_result_t step_out [2];
    int           step_n;
    link_result_t pending_results [$];
    link_result_t head_result;
    probe_row_t   probe_rows [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int bytes_sent = 0;
    int frames_seen = 0;
    int frames_clean = 0;
    int results_compared = 0;
    int mismatches = 0;

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return 16;
    endfunction

    function automatic logic [7:0] to_hex_char(input logic [3:0] nib, input logic lower);
        if (nib < 4'd10) return CH_ZERO + {4'h0, nib};
        return (lower ? CH_LA : CH_UA) + {4'h0, nib} - 8'd10;
    endfunction

    function automatic void clear_frame_state();
        seen_count = '0;
        for (int k = 0; k < TAIL_DEPTH; k++) tail[k] = '0;
        fcs_acc = '0;
        start_good = 1'b0;
        node_good = 1'b0;
        node_val = '0;
        hdr[0] = '0;
        hdr[1] = '0;
    endfunction

    // results caused by one accepted request, left in step_out[0 .. step_n-1]
    function automatic void frame_predict(input logic [7:0] b, input logic last);
        logic [10:0]  idx;
        logic [7:0]   oldest;
        int           flen;
        int           hi;
        int           lo;
        status_t      st;
        link_result_t r;
        idx = seen_count;
        oldest = tail[TAIL_DEPTH-1];
        step_n = 0;
        if (idx == 0) start_good = (b == CH_AT);
        if (idx == 1) begin
            node_good = (b >= CH_ZERO && b <= CH_NINE);
            node_val = node_good ? 7'((b - CH_ZERO) * 10) : 7'd0;
        end
        if (idx == 2) begin
            node_good = node_good && (b >= CH_ZERO && b <= CH_NINE);
            if (node_good) node_val = node_val + 7'(b - CH_ZERO);
        end
        if (idx == 3) hdr[0] = b;
        if (idx == 4) hdr[1] = b;
        if (idx >= 4) fcs_acc = fcs_acc ^ oldest;
        if (idx >= TAIL_FIRST) begin
            r = '0;
            r.kind = KIND_TEXT;
            r.text = oldest;
            step_out[0] = r;
            step_n = 1;
        end
        if (!last) begin
            for (int k = TAIL_DEPTH - 1; k > 0; k--) tail[k] = tail[k-1];
            tail[0] = b;
            if (seen_count != COUNT_MAX) seen_count = seen_count + 11'd1;
            if (step_n > 0) step_out[0].run_end = 1'b1;
            return;
        end
        flen = int'(idx) + 1;
        st = ST_OK;
        if (flen < MIN_FRAME_LEN) begin
            st = ST_SHORT;
        end else if (idx >= COUNT_MAX || flen > MAX_FRAME_LEN) begin
            st = ST_TOO_LONG;
        end else if (!start_good || tail[0] != CH_STAR || b != CH_CR) begin
            st = ST_BAD_FRAME;
        end else if (!node_good) begin
            st = ST_BAD_NODE;
        end else begin
            hi = hex_value(tail[2]);
            lo = hex_value(tail[1]);
            if (hi > 15 || lo > 15) st = ST_FCS_NOT_HEX;
            else if (((hi << 4) | lo) != int'(fcs_acc)) st = ST_FCS_MISMATCH;
        end
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        r.run_end = 1'b1;
        if (st == ST_OK) begin
            r.node = node_val;
            r.hdr_first = hdr[0];
            r.hdr_second = hdr[1];
            r.text_count = 10'((flen - MIN_FRAME_LEN > TLEN_CAP) ? TLEN_CAP
                                                                : flen - MIN_FRAME_LEN);
            frames_clean++;
        end
        step_out[step_n] = r;
        step_n++;
        frames_seen++;
        clear_frame_state();
    endfunction

    function automatic link_result_t status_only(input status_t st, input logic [6:0] node,
                                                 input logic [7:0] h1, input logic [7:0] h2);
        link_result_t r;
        r = '0;
        r.kind = KIND_STATUS;
        r.node = node;
        r.hdr_first = h1;
        r.hdr_second = h2;
        r.status = st;
        r.run_end = 1'b1;
        return r;
    endfunction

    function automatic void add_probe(input logic [7:0] b, input logic last,
                                      input logic typed, input link_result_t res);
        probe_row_t row;
        row.data = b;
        row.last = last;
        row.typed = typed;
        row.res = res;
        probe_rows.push_back(row);
    endfunction

    function automatic void match_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
        end
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input link_result_t res);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_final_byte <= last;
        do @(posedge aclk); while (!s_ready);
        frame_predict(b, last);
        if (typed) begin
            pending_results.push_back(res);
        end else begin
            for (int k = 0; k < step_n; k++) pending_results.push_back(step_out[k]);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_frame(input int len, input frame_fault_t fault);
        logic [7:0] fb [$];
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] flip;
        int         k;
        fb = {};
        if (fault == FT_NOISE || len < MIN_FRAME_LEN) begin
            for (k = 0; k < len; k++) fb.push_back(8'($urandom_range(255)));
        end else begin
            fb.push_back(CH_AT);
            fb.push_back(CH_ZERO + 8'($urandom_range(9)));
            fb.push_back(CH_ZERO + 8'($urandom_range(9)));
            fb.push_back(8'($urandom_range(255)));
            fb.push_back(8'($urandom_range(255)));
            for (k = 0; k < len - MIN_FRAME_LEN; k++) fb.push_back(8'($urandom_range(255)));
            sum = '0;
            for (k = 0; k < fb.size(); k++) sum = sum ^ fb[k];
            if (fault == FT_FCS_WRONG) begin
                flip = 8'($urandom_range(1, 255));
                sum = sum ^ flip;
            end
            fb.push_back(to_hex_char(sum[7:4], 1'($urandom_range(1))));
            fb.push_back(to_hex_char(sum[3:0], 1'($urandom_range(1))));
            fb.push_back(CH_STAR);
            fb.push_back(CH_CR);
            c = 8'($urandom_range(255));
            case (fault)
                FT_BAD_START: begin
                    if (c == CH_AT) c = ~c;
                    fb[0] = c;
                end
                FT_BAD_STAR: begin
                    if (c == CH_STAR) c = ~c;
                    fb[len-2] = c;
                end
                FT_BAD_CR: begin
                    if (c == CH_CR) c = ~c;
                    fb[len-1] = c;
                end
                FT_BAD_NODE: begin
                    if (c >= CH_ZERO && c <= CH_NINE) c = c ^ 8'h80;
                    fb[1 + $urandom_range(1)] = c;
                end
                FT_FCS_NOT_HEX: begin
                    while (hex_value(c) < 16) c = 8'($urandom_range(255));
                    fb[len - 4 + $urandom_range(1)] = c;
                end
                default: ;
            endcase
        end
        for (k = 0; k < fb.size(); k++) send_byte(fb[k], k == fb.size() - 1, 1'b0, '0);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with none expected, got kind %0d status %0d",
                         $time, m_kind, m_status);
            end else begin
                head_result = pending_results.pop_front();
                match_field("kind", head_result.kind, m_kind);
                match_field("text_byte", head_result.text, m_text_byte);
                match_field("node_number", head_result.node, m_node_number);
                match_field("header_first", head_result.hdr_first, m_header_first);
                match_field("header_second", head_result.hdr_second, m_header_second);
                match_field("text_length", head_result.text_count, m_text_length);
                match_field("status", head_result.status, m_status);
                match_field("run_end", head_result.run_end, m_run_end);
                results_compared++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int           pick;
        int           len;
        frame_fault_t fault;
        clear_frame_state();

        add_probe(8'hFF, 1'b1, 1'b1, status_only(ST_SHORT, 7'd0, 8'h00, 8'h00));
        add_probe(CH_AT, 1'b0, 1'b0, '0);
        add_probe("0", 1'b0, 1'b0, '0);
        add_probe("0", 1'b0, 1'b0, '0);
        add_probe("R", 1'b0, 1'b0, '0);
        add_probe("D", 1'b0, 1'b0, '0);
        add_probe("5", 1'b0, 1'b0, '0);
        add_probe("6", 1'b0, 1'b0, '0);
        add_probe(CH_STAR, 1'b0, 1'b0, '0);
        add_probe(CH_CR, 1'b1, 1'b1, status_only(ST_OK, 7'd0, "R", "D"));
        add_probe(CH_AT, 1'b0, 1'b0, '0);
        add_probe("9", 1'b0, 1'b0, '0);
        add_probe("9", 1'b0, 1'b0, '0);
        add_probe("W", 1'b0, 1'b0, '0);
        add_probe("R", 1'b0, 1'b0, '0);
        add_probe("a", 1'b0, 1'b0, '0);
        add_probe("2", 1'b0, 1'b0, '0);
        add_probe("4", 1'b0, 1'b0, '0);
        add_probe(CH_STAR, 1'b0, 1'b0, '0);
        add_probe(CH_CR, 1'b1, 1'b0, '0);
        add_probe(8'h00, 1'b1, 1'b1, status_only(ST_SHORT, 7'd0, 8'h00, 8'h00));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        src_idle_pct = 23;
        snk_idle_pct = 66;

        foreach (probe_rows[k])
            send_byte(probe_rows[k].data, probe_rows[k].last, probe_rows[k].typed,
                      probe_rows[k].res);
        hold_until_drained();

        while (bytes_sent < 800) begin
            if (bytes_sent >= 540) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (bytes_sent >= 270) begin
                src_idle_pct = 66;
                snk_idle_pct = 23;
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_frame($urandom_range(1, 8), FT_NOISE);
            end else if (pick < 14) begin
                send_frame($urandom_range(9, 40), FT_NOISE);
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 200) : $urandom_range(9, 39);
                fault = ($urandom_range(99) < 65) ? FT_NONE
                        : frame_fault_t'($urandom_range(FT_BAD_START, FT_FCS_WRONG));
                send_frame(len, fault);
            end
            if ($urandom_range(19) == 0) hold_until_drained();
        end

        // one past the longest legal frame
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_frame(MAX_FRAME_LEN + 1, FT_NONE);

        hold_until_drained();
        repeat (8) @(posedge aclk);
        $display("Run covered %0d request bytes in %0d frames (%0d clean), %0d results compared.",
                 bytes_sent, frames_seen, frames_clean, results_compared);
        $display("Stall mixes 23/66, 66/23 and none; short, noisy, flawed and over-long frames.");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/hfc_pkg.sv
hw/rtl/hfc_front.sv
hw/rtl/hfc_queue.sv
hw/rtl/hfc_back.sv
hw/rtl/hostlink_frame_checker.sv
bench/tb_hostlink_frame_checker.sv
